/* design/tpe_pkg.sv */
// Shared types, field widths and register codes of the trivariate polynomial evaluator.
`timescale 1ns / 1ps
`default_nettype none

package tpe_pkg;

	localparam int COEF_W     = 32;
	localparam int COORD_W    = 18;
	localparam int INDEX_W    = 8;
	localparam int OUT_W      = 48;
	localparam int ROUND_W    = COEF_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int DEG_W      = 3;
	localparam int TOTAL_W    = 4;
	localparam int EXP_W      = TOTAL_W + 1;

	localparam logic [DEG_W-1:0]   DEGREE_RESET = 3'd1;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET  = 4'd15;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEGREE_U  = 3'd0,
		REG_DEGREE_V  = 3'd1,
		REG_DEGREE_W  = 3'd2,
		REG_MAX_TOTAL = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [DEG_W-1:0]   degree_u;
		logic [DEG_W-1:0]   degree_v;
		logic [DEG_W-1:0]   degree_w;
		logic [TOTAL_W-1:0] max_total_degree;
	} cfg_t;

endpackage

`default_nettype wire

/* design/tpe_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 216
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* design/tpe_mul.sv */
// Shared signed multiplier with a product stage and a round-half-up stage.
`timescale 1ns / 1ps
`default_nettype none

module tpe_mul
	import tpe_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire                        clk,
	input  wire signed [COEF_W-1:0]    a,
	input  wire signed [FRAC_BITS+1:0] b,
	output logic signed [ROUND_W-1:0]  rnd
);

	localparam int PW  = FRAC_BITS + 2;
	localparam int P_W = COEF_W + PW;
	localparam logic [P_W-1:0] HALF = P_W'(1) << (FRAC_BITS - 1);

	logic signed [P_W-1:0]     prod_s1;
	logic [P_W-1:0]            biased;
	logic signed [ROUND_W-1:0] rnd_s2;

	assign biased = prod_s1 + HALF;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		rnd_s2  <= $signed(biased[P_W-1:FRAC_BITS]);
	end

	assign rnd = rnd_s2;

endmodule

`default_nettype wire

/* design/tpe_seq.sv */
// Sequencer: power formation, monomial walk, accumulation and the result register.
`timescale 1ns / 1ps
`default_nettype none

module tpe_seq
	import tpe_pkg::*;
#(
	parameter int MAX_DEGREE = 5,
	parameter int FRAC_BITS  = 16
) (
	input  wire                                                   clk,
	input  wire                                                   arst_n,
	input  wire cfg_t                                             cfg,
	input  wire                                                   eval_start,
	input  wire signed [COORD_W-1:0]                              u_coord,
	input  wire signed [COORD_W-1:0]                              v_coord,
	input  wire signed [COORD_W-1:0]                              w_coord,
	output logic                                                  in_stall,
	output logic                                                  ram_re,
	output logic [$clog2((MAX_DEGREE+1)*(MAX_DEGREE+1)*(MAX_DEGREE+1))-1:0] ram_raddr,
	input  wire [COEF_W-1:0]                                      ram_rdata,
	output logic signed [COEF_W-1:0]                              mul_a,
	output logic signed [FRAC_BITS+1:0]                           mul_b,
	input  wire signed [ROUND_W-1:0]                              mul_rnd,
	output logic                                                  out_valid,
	input  wire                                                   out_stall,
	output logic signed [OUT_W-1:0]                               poly_value,
	output logic                                                  overflow
);

	localparam int SIDE   = MAX_DEGREE + 1;
	localparam int DEPTH  = SIDE * SIDE * SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SLOT_W = $clog2(DEPTH + 1);
	localparam int DW     = $clog2(SIDE);
	localparam int NW     = $clog2(SIDE + 1);
	localparam int PW     = FRAC_BITS + 2;
	localparam int ACC_W  = ROUND_W + SLOT_W;
	localparam int SAT_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W;
	localparam int CMP_W  = (PW > COORD_W) ? PW : COORD_W;

	localparam logic signed [PW-1:0] ONE_P = {2'b01, {FRAC_BITS{1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE,
		S_POW_ISSUE,
		S_POW_WAIT,
		S_POW_STORE,
		S_CHECK,
		S_UV_WAIT,
		S_UV,
		S_MONO_WAIT,
		S_MONO,
		S_TERM_WAIT,
		S_TERM,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		AX_U,
		AX_V,
		AX_W
	} axis_t;

	function automatic logic signed [PW-1:0] clamp_coord(input logic signed [COORD_W-1:0] raw);
		logic signed [CMP_W-1:0] x;
		logic signed [CMP_W-1:0] hi;
		x  = CMP_W'(raw);
		hi = CMP_W'(ONE_P);
		if (x > hi) begin
			return ONE_P;
		end else if (x < -hi) begin
			return -ONE_P;
		end
		return PW'(x);
	endfunction

	function automatic logic [DW-1:0] clamp_deg(input logic [DEG_W-1:0] d);
		if (int'(d) > MAX_DEGREE) begin
			return DW'(MAX_DEGREE);
		end
		return DW'(d);
	endfunction

	state_t                  state_q;
	axis_t                   axis_q;
	logic [NW-1:0]           n_q;
	logic signed [PW-1:0]    last_q;
	logic signed [PW-1:0]    xu_q, xv_q, xw_q;
	logic signed [PW-1:0]    pu_q [SIDE];
	logic signed [PW-1:0]    pv_q [SIDE];
	logic signed [PW-1:0]    pw_q [SIDE];
	logic [DW-1:0]           i_q, j_q, k_q;
	logic [SLOT_W-1:0]       slot_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] poly_q;
	logic                    ovf_q;

	logic [DW-1:0]           du, dv, dw, deg_sel;
	logic signed [PW-1:0]    x_sel, rnd_p;
	logic                    pow_more, kept, last;
	logic [EXP_W-1:0]        exp_sum;
	logic [DW-1:0]           i_nx, j_nx, k_nx;
	logic signed [SAT_W-1:0] acc_x;
	logic                    sat_hi, sat_lo;
	logic signed [OUT_W-1:0] sat_val;

	assign du = clamp_deg(cfg.degree_u);
	assign dv = clamp_deg(cfg.degree_v);
	assign dw = clamp_deg(cfg.degree_w);

	always_comb begin
		case (axis_q)
			AX_U: begin
				deg_sel = du;
				x_sel   = xu_q;
			end
			AX_V: begin
				deg_sel = dv;
				x_sel   = xv_q;
			end
			AX_W: begin
				deg_sel = dw;
				x_sel   = xw_q;
			end
			default: begin
				deg_sel = dw;
				x_sel   = xw_q;
			end
		endcase
	end

	assign pow_more = n_q <= NW'(deg_sel);
	assign rnd_p    = $signed(mul_rnd[PW-1:0]);
	assign exp_sum  = EXP_W'(i_q) + EXP_W'(j_q) + EXP_W'(k_q);
	assign kept     = exp_sum <= EXP_W'(cfg.max_total_degree);
	assign last     = (i_q == du) && (j_q == dv) && (k_q == dw);

	always_comb begin
		i_nx = i_q + DW'(1);
		j_nx = j_q;
		k_nx = k_q;
		if (i_q == du) begin
			i_nx = '0;
			j_nx = j_q + DW'(1);
			if (j_q == dv) begin
				j_nx = '0;
				k_nx = k_q + DW'(1);
			end
		end
	end

	always_comb begin
		case (state_q)
			S_POW_ISSUE: begin
				mul_a = COEF_W'(last_q);
				mul_b = x_sel;
			end
			S_CHECK: begin
				mul_a = COEF_W'(pu_q[i_q]);
				mul_b = pv_q[j_q];
			end
			S_UV: begin
				mul_a = COEF_W'(rnd_p);
				mul_b = pw_q[k_q];
			end
			S_MONO: begin
				mul_a = $signed(ram_rdata);
				mul_b = rnd_p;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign ram_re    = (state_q == S_CHECK) && kept;
	assign ram_raddr = slot_q[ADDR_W-1:0];

	assign acc_x   = SAT_W'(acc_q);
	assign sat_hi  = acc_x > SAT_W'(OUT_MAX);
	assign sat_lo  = acc_x < SAT_W'(OUT_MIN);
	assign sat_val = sat_hi ? OUT_MAX : (sat_lo ? OUT_MIN : $signed(acc_x[OUT_W-1:0]));

	always_ff @(posedge clk) begin
		if (eval_start) begin
			pu_q[0] <= ONE_P;
			pv_q[0] <= ONE_P;
			pw_q[0] <= ONE_P;
		end
		if (state_q == S_POW_STORE) begin
			case (axis_q)
				AX_U:    pu_q[n_q[DW-1:0]] <= rnd_p;
				AX_V:    pv_q[n_q[DW-1:0]] <= rnd_p;
				default: pw_q[n_q[DW-1:0]] <= rnd_p;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= AX_U;
			n_q         <= '0;
			last_q      <= '0;
			xu_q        <= '0;
			xv_q        <= '0;
			xw_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			slot_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			poly_q      <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (state_q == S_FINISH && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (eval_start) begin
						xu_q    <= clamp_coord(u_coord);
						xv_q    <= clamp_coord(v_coord);
						xw_q    <= clamp_coord(w_coord);
						axis_q  <= AX_U;
						n_q     <= NW'(1);
						last_q  <= ONE_P;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						slot_q  <= '0;
						acc_q   <= '0;
						state_q <= S_POW_ISSUE;
					end
				end
				S_POW_ISSUE: begin
					if (pow_more) begin
						state_q <= S_POW_WAIT;
					end else begin
						n_q    <= NW'(1);
						last_q <= ONE_P;
						case (axis_q)
							AX_U:    axis_q <= AX_V;
							AX_V:    axis_q <= AX_W;
							default: state_q <= S_CHECK;
						endcase
					end
				end
				S_POW_WAIT: state_q <= S_POW_STORE;
				S_POW_STORE: begin
					last_q  <= rnd_p;
					n_q     <= n_q + NW'(1);
					state_q <= S_POW_ISSUE;
				end
				S_CHECK: begin
					if (kept) begin
						state_q <= S_UV_WAIT;
					end else if (last) begin
						state_q <= S_FINISH;
					end else begin
						i_q <= i_nx;
						j_q <= j_nx;
						k_q <= k_nx;
					end
				end
				S_UV_WAIT:   state_q <= S_UV;
				S_UV:        state_q <= S_MONO_WAIT;
				S_MONO_WAIT: state_q <= S_MONO;
				S_MONO:      state_q <= S_TERM_WAIT;
				S_TERM_WAIT: state_q <= S_TERM;
				S_TERM: begin
					acc_q  <= acc_q + ACC_W'(mul_rnd);
					slot_q <= slot_q + SLOT_W'(1);
					if (last) begin
						state_q <= S_FINISH;
					end else begin
						i_q     <= i_nx;
						j_q     <= j_nx;
						k_q     <= k_nx;
						state_q <= S_CHECK;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						poly_q  <= sat_val;
						ovf_q   <= sat_hi || sat_lo;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall   = state_q != S_IDLE;
	assign out_valid  = out_valid_q;
	assign poly_value = poly_q;
	assign overflow   = ovf_q;

	a_busy_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		eval_start |=> in_stall)
		else $error("Block accepted a further item while an evaluation was running.");

	a_coef_read_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MONO) |-> $past(ram_re, 4))
		else $error("Coefficient product issued without a matching table read.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("Result appeared without a finished evaluation.");

	a_overflow_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && ovf_q) |-> (poly_q == OUT_MAX || poly_q == OUT_MIN))
		else $error("Overflow flagged but the value is not at a saturation bound.");

endmodule

`default_nettype wire

/* design/trivariate_polynomial_evaluator.sv */
// Top level of the trivariate polynomial evaluator: registers, table, multiplier, sequencer.
//
// Channel   Handshake                 Payload
// input     in_valid / in_stall       opcode, coef_index, coef_value, u_coord, v_coord, w_coord
// output    out_valid / out_stall     poly_value, overflow
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A write item is taken whenever the block is idle. An evaluate item holds in_stall until
// its result is registered, so no new item is taken before the last one is through; the
// pace is set by the single shared multiplier and its product and rounding stages.
// Reset clears the configuration and control state; the coefficient table is not cleared.
// A result waiting under out_stall does not block the next item, only the next result.
`timescale 1ns / 1ps
`default_nettype none

module trivariate_polynomial_evaluator
	import tpe_pkg::*;
#(
	parameter int MAX_DEGREE = 5,
	parameter int FRAC_BITS  = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire                      opcode,
	input  wire [INDEX_W-1:0]        coef_index,
	input  wire signed [COEF_W-1:0]  coef_value,
	input  wire signed [COORD_W-1:0] u_coord,
	input  wire signed [COORD_W-1:0] v_coord,
	input  wire signed [COORD_W-1:0] w_coord,
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic signed [OUT_W-1:0]  poly_value,
	output logic                     overflow,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire [CFG_IDX_W-1:0]      cfg_index,
	input  wire [CFG_DATA_W-1:0]     cfg_data
);

	localparam int SIDE   = MAX_DEGREE + 1;
	localparam int DEPTH  = SIDE * SIDE * SIDE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PW     = FRAC_BITS + 2;

	cfg_t                      cfg_q;
	logic                      in_accept, eval_start, coef_we;
	logic                      ram_re;
	logic [ADDR_W-1:0]         ram_raddr, ram_waddr;
	logic [COEF_W-1:0]         ram_rdata;
	logic signed [COEF_W-1:0]  mul_a;
	logic signed [PW-1:0]      mul_b;
	logic signed [ROUND_W-1:0] mul_rnd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.degree_u         <= DEGREE_RESET;
			cfg_q.degree_v         <= DEGREE_RESET;
			cfg_q.degree_w         <= DEGREE_RESET;
			cfg_q.max_total_degree <= TOTAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEGREE_U:  cfg_q.degree_u         <= cfg_data[DEG_W-1:0];
				REG_DEGREE_V:  cfg_q.degree_v         <= cfg_data[DEG_W-1:0];
				REG_DEGREE_W:  cfg_q.degree_w         <= cfg_data[DEG_W-1:0];
				REG_MAX_TOTAL: cfg_q.max_total_degree <= cfg_data[TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_accept  = in_valid && !in_stall;
	assign eval_start = in_accept && (opcode == OP_EVAL);
	assign coef_we    = in_accept && (opcode == OP_WRITE) && (int'(coef_index) < DEPTH);
	assign ram_waddr  = ADDR_W'(coef_index);

	tpe_ram #(
		.WIDTH(COEF_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (coef_we),
		.waddr(ram_waddr),
		.wdata(coef_value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tpe_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.rnd(mul_rnd)
	);

	tpe_seq #(
		.MAX_DEGREE(MAX_DEGREE),
		.FRAC_BITS (FRAC_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.eval_start(eval_start),
		.u_coord   (u_coord),
		.v_coord   (v_coord),
		.w_coord   (w_coord),
		.in_stall  (in_stall),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.mul_rnd   (mul_rnd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.poly_value(poly_value),
		.overflow  (overflow)
	);

endmodule

`default_nettype wire
